@@ rtl/hufd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants for the Huffman tree decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int NODE_COUNT_DEF = 512;
    localparam int IDX_W          = 9;    // width of node and child indexes
    localparam int SYM_W          = 8;
    localparam int CODE_W         = 8;
    localparam int MAX_SYMS       = 8;    // at most one symbol per code bit
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 8;
    localparam int M_TUSER_W      = 2;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic             is_leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] left;
        logic             left_present;
        logic [IDX_W-1:0] right;
        logic             right_present;
    } node_entry_t;

endpackage

@@ rtl/hufd_node_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufd_node_ram
// Node table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hufd_node_ram
    import hufd_pkg::*;
#(
    parameter int DEPTH = NODE_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  node_entry_t   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output node_entry_t   rdata
);

    node_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/huffman_tree_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Walks a binary code tree held in a node table, one code bit at a time.
// ----------------------------------------------------------------------------
// Input stream (s_): s_tuser selects the kind of transfer. A node write stores
// one tree node, sends the walk back to the root and clears the broken flag;
// it gives no result and the sequencer stays idle. A decode transfer carries one
// code byte, walked MSB first (0 = left child, 1 = right child).
// Each code bit is walked in a step phase, which issues a node-table read from
// the current node, and a read phase, which takes the registered read data
// (leaf test, next node). The root entry is kept in a register so a return to
// the root needs no node-table read. The walk of a byte stops early once it
// breaks; then results go into the output register: one result per symbol
// found, or a single empty result, tlast on the final one. broken is only
// known once the whole byte is walked, so results are buffered first.
// s_tready is high only while the sequencer is idle; the output register lets
// the next item be taken while the final result still waits. A stalled
// receiver holds the sequencer in its emit phase.
// Reset clears the walk to the root, the broken flag and the output valid; the
// node table is not cleared and must be written before it is used.
// ----------------------------------------------------------------------------
module huffman_tree_decoder
    import hufd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [8:0] node_index, [9] node_is_leaf, [17:10] node_symbol,
    // [26:18] left_child, [27] left_present, [36:28] right_child,
    // [37] right_present, [45:38] code_byte, [47:46] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] symbol
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] has_symbol, [1] broken
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int AW = $clog2(NODE_COUNT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [2:0]        bit_reg, bit_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [2:0]        emit_reg, emit_next;
    logic              broken_reg, broken_next;
    node_entry_t       cur_reg, cur_next;
    node_entry_t       root_reg, root_next;
    logic [SYM_W-1:0]  buf_reg [MAX_SYMS];
    logic              buf_we;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [SYM_W-1:0]  m_sym_reg, m_sym_next;
    logic              m_has_reg, m_has_next;
    logic              m_broken_reg, m_broken_next;
    logic              m_last_reg, m_last_next;

    // input fields
    logic [IDX_W-1:0]  in_index;
    node_entry_t       in_entry;
    logic [CODE_W-1:0] in_code;
    logic              s_xfer;
    logic              in_range;

    // walk step
    logic              code_bit;
    logic [IDX_W-1:0]  child;
    logic              child_present;
    logic              child_ok;
    logic              out_free;
    logic              is_last;

    // node table port
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    node_entry_t       ram_rdata;

    assign in_index               = s_tdata[8:0];
    assign in_entry.is_leaf       = s_tdata[9];
    assign in_entry.symbol        = s_tdata[17:10];
    assign in_entry.left          = s_tdata[26:18];
    assign in_entry.left_present  = s_tdata[27];
    assign in_entry.right         = s_tdata[36:28];
    assign in_entry.right_present = s_tdata[37];
    assign in_code                = s_tdata[45:38];

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign in_range = (32'(in_index) < NODE_COUNT);
    assign ram_we   = s_xfer && (s_tuser == MODE_WRITE) && in_range;

    assign code_bit      = code_reg[bit_reg];
    assign child         = code_bit ? cur_reg.right : cur_reg.left;
    assign child_present = code_bit ? cur_reg.right_present : cur_reg.left_present;
    assign child_ok      = child_present && (32'(child) < NODE_COUNT);
    assign ram_raddr     = AW'(child);
    assign ram_re        = (state_reg == S_STEP) && !broken_reg && child_ok;

    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (cnt_reg == 4'd0) || ({1'b0, emit_reg} == cnt_reg - 4'd1);

    hufd_node_ram #(
        .DEPTH (NODE_COUNT),
        .AW    (AW)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_index)),
        .wdata (in_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        bit_next      = bit_reg;
        cnt_next      = cnt_reg;
        emit_next     = emit_reg;
        broken_next   = broken_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        buf_we        = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_sym_next    = m_sym_reg;
        m_has_next    = m_has_reg;
        m_broken_next = m_broken_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == MODE_WRITE) begin
                        broken_next = 1'b0;
                        if (in_index == '0) begin
                            root_next = in_entry;
                            cur_next  = in_entry;
                        end else begin
                            cur_next  = root_reg;
                        end
                    end else begin
                        code_next  = in_code;
                        bit_next   = 3'd7;
                        cnt_next   = 4'd0;
                        emit_next  = 3'd0;
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP: begin
                // once broken, the remaining bits of the byte do nothing
                if (broken_reg) begin
                    state_next = S_EMIT;
                end else if (!child_ok) begin
                    broken_next = 1'b1;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (ram_rdata.is_leaf) begin
                    buf_we   = 1'b1;
                    cnt_next = cnt_reg + 4'd1;
                    cur_next = root_reg;
                end else begin
                    cur_next = ram_rdata;
                end
                if (bit_reg == 3'd0) begin
                    state_next = S_EMIT;
                end else begin
                    bit_next   = bit_reg - 3'd1;
                    state_next = S_STEP;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_has_next    = (cnt_reg != 4'd0);
                    m_sym_next    = (cnt_reg != 4'd0) ? buf_reg[emit_reg] : '0;
                    m_broken_next = broken_reg;
                    m_last_next   = is_last;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        emit_next = emit_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            broken_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= 4'd0;
            emit_reg     <= 3'd0;
        end else begin
            state_reg    <= state_next;
            broken_reg   <= broken_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            emit_reg     <= emit_next;
        end
    end

    // walk position after reset is the root, whose entry sits in root_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= root_reg;
        end else begin
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        bit_reg      <= bit_next;
        root_reg     <= root_next;
        m_sym_reg    <= m_sym_next;
        m_has_reg    <= m_has_next;
        m_broken_reg <= m_broken_next;
        m_last_reg   <= m_last_next;
        if (buf_we) begin
            buf_reg[cnt_reg[2:0]] <= ram_rdata.symbol;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_sym_reg;
    assign m_tuser  = {m_broken_reg, m_has_reg};
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    // a broken walk reads no further nodes for this byte
    a_broken_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP && broken_reg) |=> (state_reg == S_EMIT))
        else $error("broken walk did not go straight to emit");

    // every leaf test is preceded by a node read issued from the step phase
    a_read_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> ($past(state_reg) == S_STEP && $past(ram_re)))
        else $error("read phase without an issued node read");

    // a byte has eight bits, so never more than eight symbols
    a_sym_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 4'd8)
        else $error("symbol count overflow");

    // the final result of a byte leaves the sequencer idle
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free && is_last) |=>
            (state_reg == S_IDLE && m_tvalid && m_tlast))
        else $error("final result not flagged or sequencer not idle");
`endif

endmodule
